// ===== rtl/core/rcsw_pkg.sv =====
package rcsw_pkg;

    // field and register widths
    localparam int PW     = 16;            // pulse width, config registers
    localparam int FRAC   = 13;            // Q2.13 fraction bits
    localparam int QW     = PW + FRAC;     // dividend / quotient bits
    localparam int QCW    = $clog2(QW);    // divider step counter
    localparam int SW     = 2;             // switch position
    localparam int CFG_AW = 2;             // config index
    localparam int OUT_DW = 24;            // output tdata, padded to bytes

    // config register indexes
    localparam logic [CFG_AW-1:0] CFG_CENTER  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MINIMUM = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MAXIMUM = 2'd2;

    localparam logic [PW-1:0] CENTER_RST  = 16'd1500;
    localparam logic [PW-1:0] MINIMUM_RST = 16'd1000;
    localparam logic [PW-1:0] MAXIMUM_RST = 16'd2000;

    // half-range below this gives a zero deflection
    localparam logic [PW-1:0] MIN_HALF = 16'd100;

    // 20 * d < 8192  <=>  d <= 409 ; 3 * m < 8192  <=>  m <= 2730
    localparam logic [PW:0] STEADY_LIMIT = 17'd409;
    localparam logic [PW:0] THIRD_LIMIT  = 17'd2730;

    localparam logic [QW-1:0] POS_LIMIT = 29'd32767;
    localparam logic [QW-1:0] NEG_LIMIT = 29'd32768;
    localparam logic [PW-1:0] Q_MAX     = 16'h7fff;
    localparam logic [PW-1:0] Q_MIN     = 16'h8000;

    localparam logic [SW-1:0] POS_MID  = 2'b00;
    localparam logic [SW-1:0] POS_HIGH = 2'b01;
    localparam logic [SW-1:0] POS_LOW  = 2'b11;

    typedef struct packed {
        logic          start;
        logic [PW-1:0] mag;    // |width - center|
        logic [PW-1:0] den;    // half-range in use
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;            // one-cycle pulse, quotient valid
    } div_stat_t;

endpackage

// ===== rtl/core/rc_three_position_switch_top.sv =====
// Three-position switch decoded from one RC receiver channel.
//
// Input channel s_*: one request per measured pulse. s_tdata carries the
// pulse width in timer units, s_tuser the pulse-seen flag.
// Output channel m_*: one result per request. m_tdata carries the switch
// position (-1 low, 0 middle, +1 high) and the Q2.13 normalized deflection.
// Config port: cfg_wr_en / cfg_addr / cfg_wdata writes center (0),
// minimum (1) or maximum (2); other indexes are dropped. Write only while
// the block is idle.
//
// Sequence when a division runs, from input accept to m_tvalid: setup,
// 29 divider steps of one quotient bit each, quotient capture, decide
// and output. A narrow half-range skips the divider steps and capture;
// without a pulse, decide is skipped too. One request is in flight at a
// time; the next one is accepted the cycle after the result is loaded,
// so the request rate is set by the bit-serial divider.
//
// Reset (aresetn low, synchronous) restores the default pulse limits,
// clears the previous value and puts the switch in the middle position.
// A stalled receiver holds the result in the output register; the next
// request is still accepted and computed, then waits until it is taken.
module rc_three_position_switch_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rcsw_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [rcsw_pkg::PW-1:0]     cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rcsw_pkg::PW-1:0]     s_tdata,   // [15:0] pulse_width
    input  logic [0:0]                  s_tuser,   // [0] pulse_seen
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rcsw_pkg::OUT_DW-1:0] m_tdata    // [1:0] switch_position,
                                                   // [17:2] normalized_value
);
    import rcsw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DECIDE,
        ST_OUT
    } state_t;

    state_t         state_reg;

    logic [PW-1:0]  center_reg;
    logic [PW-1:0]  minimum_reg;
    logic [PW-1:0]  maximum_reg;

    logic [PW-1:0]  width_reg;
    logic           seen_reg;
    logic           neg_reg;       // width below center
    logic [PW-1:0]  value_reg;     // deflection of the current request
    logic [PW-1:0]  prev_reg;
    logic [SW-1:0]  switch_state_reg;

    logic           m_tvalid_reg;
    logic [SW-1:0]  m_pos_reg;
    logic [PW-1:0]  m_value_reg;

    // setup: side of center, offset magnitude, half-range in use
    logic           below;
    logic [PW-1:0]  offset;
    logic [PW:0]    half;          // signed, registers may be out of order
    logic           narrow;

    assign below  = width_reg < center_reg;
    assign offset = below ? (center_reg - width_reg) : (width_reg - center_reg);
    assign half   = below ? ({1'b0, center_reg} - {1'b0, minimum_reg})
                          : ({1'b0, maximum_reg} - {1'b0, center_reg});
    assign narrow = half[PW] || (half[PW-1:0] < MIN_HALF);

    div_req_t       div_req;
    div_stat_t      div_stat;
    logic [QW-1:0]  quotient;

    assign div_req.start = (state_reg == ST_PREP) && seen_reg && !narrow;
    assign div_req.mag   = offset;
    assign div_req.den   = half[PW-1:0];

    rcsw_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // saturate the quotient magnitude onto the signed Q2.13 range
    logic [PW-1:0]  sat_value;

    always_comb begin
        if (neg_reg) begin
            sat_value = (quotient > NEG_LIMIT) ? Q_MIN : (-quotient[PW-1:0]);
        end else begin
            sat_value = (quotient > POS_LIMIT) ? Q_MAX : quotient[PW-1:0];
        end
    end

    // step size against previous value, and deflection magnitude
    logic [PW:0]    step;
    logic [PW:0]    step_abs;
    logic [PW:0]    val_abs;
    logic           steady;
    logic [SW-1:0]  new_pos;

    assign step     = {value_reg[PW-1], value_reg} - {prev_reg[PW-1], prev_reg};
    assign step_abs = step[PW] ? (-step) : step;
    assign val_abs  = value_reg[PW-1] ? (-{value_reg[PW-1], value_reg})
                                      : {value_reg[PW-1], value_reg};
    assign steady   = step_abs <= STEADY_LIMIT;
    assign new_pos  = (val_abs <= THIRD_LIMIT) ? POS_MID
                    : (value_reg[PW-1] ? POS_LOW : POS_HIGH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            center_reg       <= CENTER_RST;
            minimum_reg      <= MINIMUM_RST;
            maximum_reg      <= MAXIMUM_RST;
            prev_reg         <= '0;
            switch_state_reg <= POS_MID;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_CENTER:  center_reg  <= cfg_wdata;
                    CFG_MINIMUM: minimum_reg <= cfg_wdata;
                    CFG_MAXIMUM: maximum_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // in ST_OUT the output register is reloaded below instead
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        width_reg <= s_tdata;
                        seen_reg  <= s_tuser[0];
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    neg_reg   <= below;
                    value_reg <= '0;
                    if (!seen_reg) begin
                        // no pulse: state held, deflection reported as zero
                        state_reg <= ST_OUT;
                    end else if (narrow) begin
                        state_reg <= ST_DECIDE;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        value_reg <= sat_value;
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    prev_reg <= value_reg;
                    if (steady) begin
                        switch_state_reg <= new_pos;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_pos_reg    <= switch_state_reg;
                        m_value_reg  <= value_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DW - PW - SW){1'b0}}, m_value_reg, m_pos_reg};

    // the switch never takes the unused code
    a_switch_code: assert property (@(posedge aclk) disable iff (!aresetn)
        switch_state_reg != 2'b10)
        else $error("switch state holds the unused code");

    // while waiting on the divider it must be running or just finished
    a_div_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

    // one request in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted while busy");

    // a request without a pulse never moves the switch
    a_unseen_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PREP && !seen_reg) |=> $stable(switch_state_reg))
        else $error("switch moved without a pulse");

endmodule

// ===== rtl/core/rcsw_divider.sv =====
module rcsw_divider (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rcsw_pkg::div_req_t      req,
    output rcsw_pkg::div_stat_t     stat,
    output logic [rcsw_pkg::QW-1:0] quotient
);
    import rcsw_pkg::*;

    // restoring divider, one quotient bit per cycle; dividend bits shift
    // out of the top of shift_reg while quotient bits shift in below
    logic           busy_reg;
    logic           done_reg;
    logic [QCW-1:0] cnt_reg;
    logic [QW-1:0]  shift_reg;
    logic [PW-1:0]  rem_reg;
    logic [PW-1:0]  den_reg;

    logic [PW:0]    trial;
    logic [PW:0]    trial_sub;
    logic           fits;

    assign trial     = {rem_reg, shift_reg[QW-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= QCW'(QW - 1);
                shift_reg <= {req.mag, {FRAC{1'b0}}};
                rem_reg   <= '0;
                den_reg   <= req.den;
            end else if (busy_reg) begin
                // remainder stays below den, so 16 bits hold it
                rem_reg   <= fits ? trial_sub[PW-1:0] : trial[PW-1:0];
                shift_reg <= {shift_reg[QW-2:0], fits};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = shift_reg;

endmodule

// ===== sim/tb_rc_three_position_switch_top.sv =====
`timescale 1ns / 100ps

// Testbench for the RC three-position switch decoder.
// Requests go in on s_*, results come back on m_*. A scoreboard object
// predicts every result from its own copy of the pulse limits and the
// switch state, and checks results in order. The limits are
// reprogrammed between phases, only once every outstanding result is back.
module tb_rc_three_position_switch_top;
    import rcsw_pkg::*;

    // Q2.13 constants and switch thresholds, in the predictor's own terms
    localparam int     Q_ONE       = 1 << FRAC;   // 1.0
    localparam int     STEADY_MUL  = 20;          // |delta| < 0.05  <=> 20*|delta| < 1.0
    localparam int     THIRD_MUL   = 3;           // |v| < 1/3       <=> 3*|v| < 1.0
    localparam longint DEFL_MAX    = 32767;
    localparam longint DEFL_MIN    = -32768;
    localparam int     WIDTH_TOP   = (1 << PW) - 1;

    // register index with no register behind it, writes must be dropped
    localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;

    localparam int MAX_GAP      = 7;         // per-request idle draw, both sides
    localparam int SETTLE       = 40;        // settle wait after draining, before config / end
    localparam int HOLD_AFTER   = 300;       // requests taken before the long stall
    localparam int HOLD_CYCLES  = 400;       // length of the long receiver stall
    localparam int PHASE_ITEMS  = 130;
    localparam int RAND_PHASES  = 6;
    localparam int CYCLE_LIMIT  = 600000;    // hang guard on the whole run

    typedef struct {
        logic signed [SW-1:0] position;
        logic signed [PW-1:0] value;
    } switch_result_t;

    // Predicts results and checks them in arrival order.
    class switch_scoreboard;
        logic [PW-1:0]        center, minimum, maximum;
        logic signed [PW-1:0] prev_value;
        logic signed [SW-1:0] sw_state;
        switch_result_t       pending[$];
        int                   errors;

        function new();
            center     = CENTER_RST;
            minimum    = MINIMUM_RST;
            maximum    = MAXIMUM_RST;
            prev_value = '0;
            sw_state   = POS_MID;
            errors     = 0;
        endfunction

        function void write_register(logic [CFG_AW-1:0] idx, logic [PW-1:0] val);
            case (idx)
                CFG_CENTER:  center  = val;
                CFG_MINIMUM: minimum = val;
                CFG_MAXIMUM: maximum = val;
                default: ;   // unknown index: ignored
            endcase
        endfunction

        // (width - center) / half-range in Q2.13, truncated, saturated;
        // zero when the half-range in use is narrow or negative
        function logic signed [PW-1:0] deflection(logic [PW-1:0] width);
            longint w, c, lo, hi, half, q, narrow;
            w = longint'(width);  c = longint'(center);
            lo = longint'(minimum);  hi = longint'(maximum);
            narrow = longint'(MIN_HALF);
            half = (w < c) ? c - lo : hi - c;
            if (half < narrow)
                return '0;
            q = ((w - c) * Q_ONE) / half;
            if (q > DEFL_MAX) q = DEFL_MAX;
            if (q < DEFL_MIN) q = DEFL_MIN;
            return q[PW-1:0];
        endfunction

        function void note_request(logic [PW-1:0] width, logic seen);
            switch_result_t r;
            logic signed [PW-1:0] value;
            int v, p, diff, mag;
            value = '0;
            if (seen) begin
                value = deflection(width);
                v = int'(value);
                p = int'(prev_value);
                diff = (v > p) ? v - p : p - v;
                prev_value = value;
                // position only re-decided once the stick has settled
                if (STEADY_MUL * diff < Q_ONE) begin
                    mag = (v < 0) ? -v : v;
                    if (THIRD_MUL * mag < Q_ONE)
                        sw_state = POS_MID;
                    else
                        sw_state = (v < 0) ? POS_LOW : POS_HIGH;
                end
            end
            r.position = sw_state;
            r.value    = value;
            pending.push_back(r);
        endfunction

        function void check_result(logic [OUT_DW-1:0] data);
            switch_result_t exp_r;
            logic signed [SW-1:0] got_pos;
            logic signed [PW-1:0] got_val;
            got_pos = data[SW-1:0];
            got_val = data[SW+PW-1:SW];
            if (pending.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result: position %0d value %0d", got_pos, got_val);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got_pos !== exp_r.position || got_val !== exp_r.value) begin
                if (errors < 10)
                    $display("mismatch: position exp %0d got %0d, value exp %0d got %0d",
                             exp_r.position, got_pos, exp_r.value, got_val);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [PW-1:0]       cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [PW-1:0]       s_tdata;    // [15:0] pulse_width
    logic [0:0]          s_tuser;    // [0] pulse_seen
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_DW-1:0]   m_tdata;    // [1:0] switch_position, [17:2] normalized_value

    switch_scoreboard sb = new();

    int  requests_taken = 0;
    int  cycle_count    = 0;
    bit  tx_calm        = 1'b0;      // sender stretch with no idle cycles
    bit  rx_calm        = 1'b0;      // receiver stretch with no stalls
    bit  hold_off       = 1'b0;      // long receiver stall in progress
    int  last_width;

    rc_three_position_switch_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit: anything this slow means the block hung.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Result side. Every accepted result is checked at the edge it is taken;
    // after each one the receiver draws its own random stall.
    initial begin
        int rx_gap;
        rx_gap   = 0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                rx_gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long receiver stall in mid-run: the block holds one result, computes
    // the next and then has to back-pressure the sender.
    initial begin
        int held;
        wait (requests_taken >= HOLD_AFTER);
        @(posedge aclk);
        hold_off <= 1'b1;
        held = 0;
        while (held < HOLD_CYCLES) begin
            @(posedge aclk);
            held++;
        end
        hold_off <= 1'b0;
    end

    // One request. The idle gap lowers tvalid only when there is a gap, so
    // back-to-back requests keep tvalid high without a glitch.
    task automatic send_request(input logic [PW-1:0] width, input logic seen);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= width;
        s_tuser  <= seen;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(width, seen);
        requests_taken++;
        last_width = int'(width);
    endtask

    // Stop offering and wait until every outstanding result is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic put_register(input logic [CFG_AW-1:0] idx, input logic [PW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_register(idx, val);
    endtask

    // Reprogram all three limits while idle, plus a write to the unused
    // index that must leave everything alone.
    task automatic program_limits(input int c, input int lo, input int hi);
        drain();
        put_register(CFG_UNUSED, PW'($urandom_range(0, WIDTH_TOP)));
        put_register(CFG_CENTER, PW'(c));
        put_register(CFG_MINIMUM, PW'(lo));
        put_register(CFG_MAXIMUM, PW'(hi));
        cfg_wr_en <= 1'b0;
        tx_calm <= ($urandom_range(0, 3) == 0);
        rx_calm <= ($urandom_range(0, 3) == 0);
        last_width = c;
    endtask

    function automatic int clamp_width(input int w);
        if (w < 0) return 0;
        if (w > WIDTH_TOP) return WIDTH_TOP;
        return w;
    endfunction

    // Mostly small moves around the last width so the switch settles and
    // changes position; some jumps inside the stick range, some noise.
    task automatic random_requests(input int n, input int lo, input int hi);
        int k, r, w, a, b;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                w = last_width;
            else if (r < 60)
                w = clamp_width(last_width + int'($urandom_range(0, 40)) - 20);
            else if (r < 88)
                w = $urandom_range(a, b);
            else
                w = $urandom_range(0, WIDTH_TOP);
            send_request(PW'(w), $urandom_range(0, 9) != 0);
        end
    endtask

    initial begin
        int p, c, lo, hi, span;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        last_width = int'(CENTER_RST);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, default limits 1500 / 1000 / 2000 (half-range 500).
        send_request(16'd1500, 1'b0);      // no pulse yet: middle, value 0
        send_request(16'd1500, 1'b1);      // centered, steady -> middle
        send_request(16'd2000, 1'b1);      // full up, jump too big to decide
        send_request(16'd2000, 1'b1);      // settled -> high
        send_request(16'd0, 1'b0);         // pulse lost: high held, value 0
        send_request(16'hffff, 1'b1);      // far above max -> saturates
        send_request(16'hffff, 1'b1);
        send_request(16'd0, 1'b1);         // far below min -> -3.0, inside range
        send_request(16'd0, 1'b1);         // settled -> low
        send_request(16'd1000, 1'b1);
        send_request(16'd1000, 1'b1);
        send_request(16'd1334, 1'b1);      // just under a third below
        send_request(16'd1334, 1'b1);      // -> middle
        send_request(16'd1333, 1'b1);      // just over a third below -> low
        send_request(16'd1499, 1'b1);
        send_request(16'd1501, 1'b1);
        send_request(16'd1666, 1'b1);
        send_request(16'd1666, 1'b1);      // just under a third above -> middle
        send_request(16'd1667, 1'b1);      // just over -> high
        send_request(16'd1500, 1'b1);
        send_request(16'd1525, 1'b1);      // step of 409, right at the settle edge
        send_request(16'haaaa, 1'b1);
        send_request(16'h5555, 1'b0);
        random_requests(PHASE_ITEMS, int'(MINIMUM_RST), int'(MAXIMUM_RST));

        // Extreme register settings.
        program_limits(0, 0, WIDTH_TOP);              // widest upper half
        random_requests(PHASE_ITEMS, 0, WIDTH_TOP);
        program_limits(WIDTH_TOP, 0, WIDTH_TOP);      // upper half-range zero
        send_request(16'hffff, 1'b1);
        random_requests(PHASE_ITEMS, 0, WIDTH_TOP);
        program_limits(32768, 32668, 32868);          // half-range exactly 100
        random_requests(PHASE_ITEMS, 32568, 32968);
        program_limits(32768, 32669, 32867);          // half-range 99: narrow
        random_requests(PHASE_ITEMS, 32568, 32968);
        program_limits(1000, 2000, 500);              // limits out of order
        random_requests(PHASE_ITEMS, 0, 3000);
        program_limits(0, 0, 0);
        random_requests(PHASE_ITEMS / 2, 0, 200);
        program_limits(WIDTH_TOP, WIDTH_TOP, WIDTH_TOP);
        random_requests(PHASE_ITEMS / 2, WIDTH_TOP - 200, WIDTH_TOP);

        // Random, mostly sane limits; now and then a narrow half-range.
        for (p = 0; p < RAND_PHASES; p++) begin
            c = $urandom_range(0, WIDTH_TOP);
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                               : $urandom_range(100, 4000);
            lo = clamp_width(c - span);
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                               : $urandom_range(100, 4000);
            hi = clamp_width(c + span);
            program_limits(c, lo, hi);
            random_requests(PHASE_ITEMS + 40, lo, hi);
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rcsw_pkg.sv
rtl/core/rcsw_divider.sv
rtl/core/rc_three_position_switch_top.sv
sim/tb_rc_three_position_switch_top.sv
